// ===== rtl/core/ssdps_pkg.sv =====
// Shared types, constants and helper functions for the seven-segment digit pixel shader.
package ssdps_pkg;

    localparam int CELL_WIDTH    = 10;
    localparam int CELL_HEIGHT   = 20;
    localparam int BAR_THICKNESS = 2;
    localparam int SHADOW_OFFSET = 2;

    localparam int DX_W = 10;
    localparam int DY_W = 8;

    typedef logic signed [DX_W-1:0] dx_t;
    typedef logic signed [DY_W-1:0] dy_t;
    typedef logic [6:0] seg_t;
    typedef logic [7:0] color_t;

    typedef enum logic [1:0] {
        STYLE_DEFAULT  = 2'd0,
        STYLE_CLASSIC  = 2'd1,
        STYLE_MODERN   = 2'd2,
        STYLE_CLASSIC2 = 2'd3
    } style_t;

    typedef enum logic [1:0] {
        HIT_NONE  = 2'd0,
        HIT_LIT   = 2'd1,
        HIT_CLEAR = 2'd2
    } hit_t;

    typedef enum logic [2:0] {
        REG_STYLE  = 3'd0,
        REG_SHADOW = 3'd1,
        REG_RED    = 3'd2,
        REG_GREEN  = 3'd3,
        REG_BLUE   = 3'd4
    } reg_idx_t;

    localparam logic [3:0] DIGIT_MAX = 4'd9;

    function automatic seg_t digit_segments(input logic [3:0] digit);
        seg_t s;
        unique case (digit)
            4'd0:    s = 7'b0111111;
            4'd1:    s = 7'b0000110;
            4'd2:    s = 7'b1011011;
            4'd3:    s = 7'b1001111;
            4'd4:    s = 7'b1100110;
            4'd5:    s = 7'b1101101;
            4'd6:    s = 7'b1111101;
            4'd7:    s = 7'b0000111;
            4'd8:    s = 7'b1111111;
            4'd9:    s = 7'b1101111;
            default: s = 7'b0000000;
        endcase
        return s;
    endfunction

    // floor(c*3/10): x/10 == (x*205)>>11 for x below 1029
    function automatic color_t dim_color(input color_t c);
        logic [9:0]  x;
        logic [17:0] p;
        x = 10'({c, 1'b0}) + 10'(c);
        p = 18'(x) * 18'd205;
        return {1'b0, p[17:11]};
    endfunction

endpackage

// ===== rtl/core/ssdps_pass.sv =====
// Hit evaluation of one drawing pass at a pixel relative to the cell origin.
module ssdps_pass
    import ssdps_pkg::*;
(
    input  seg_t   segs,
    input  style_t style,
    input  dx_t    dx,
    input  dy_t    dy,
    output hit_t   hit
);

    localparam int W  = CELL_WIDTH;
    localparam int H  = CELL_HEIGHT;
    localparam int T  = BAR_THICKNESS;
    localparam int HH = CELL_HEIGHT / 2;

    function automatic logic in_box(input dx_t x, input dy_t y,
                                    input int x0, input int y0, input int bw, input int bh);
        return (int'(x) >= x0) && (int'(x) < x0 + bw) && (int'(y) >= y0) && (int'(y) < y0 + bh);
    endfunction

    function automatic logic at(input dx_t x, input dy_t y, input int x0, input int y0);
        return (int'(x) == x0) && (int'(y) == y0);
    endfunction

    logic sa, sb, sc, sd, se, sf, sg;
    logic lit;
    logic clr;
    logic notch_en;

    assign {sg, sf, se, sd, sc, sb, sa} = segs;

    always_comb begin
        lit = 1'b0;
        clr = 1'b0;
        if (sa && in_box(dx, dy, 1, 0, W - 2, T)) lit = 1'b1;
        if (sb && in_box(dx, dy, W - T, 1, T, HH - 1)) lit = 1'b1;
        if (sc && in_box(dx, dy, W - T, HH, T, HH - 1)) lit = 1'b1;
        if (sd && in_box(dx, dy, 1, H - T, W - 2, T)) lit = 1'b1;
        if (se && in_box(dx, dy, 0, HH, T, HH - 1)) lit = 1'b1;
        if (sf && in_box(dx, dy, 0, 1, T, HH - 1)) lit = 1'b1;
        if (sg && in_box(dx, dy, 1, HH - 1, W - 2, T)) lit = 1'b1;

        notch_en = (style == STYLE_CLASSIC) || ((style == STYLE_CLASSIC2) && !(sa && sd));

        if (style != STYLE_MODERN) begin
            if ((sf != sa) && at(dx, dy, 0, 0)) lit = 1'b1;
            if ((sa != sb) && at(dx, dy, W - 1, 0)) lit = 1'b1;
            if ((sd != se) && at(dx, dy, 0, H - 1)) lit = 1'b1;
            if ((sc != sd) && at(dx, dy, W - 1, H - 1)) lit = 1'b1;

            if (style == STYLE_CLASSIC2) begin
                if (sf && sg && at(dx, dy, T - 1, HH - 1)) clr = 1'b1;
                if (sb && sg && at(dx, dy, W - T, HH - 1)) clr = 1'b1;
            end else begin
                if (sf && sg && at(dx, dy, 0, HH - 1)) clr = 1'b1;
                if (sb && sg && at(dx, dy, W - 1, HH - 1)) clr = 1'b1;
            end

            if (notch_en && !sg) begin
                if (sb && sc && (at(dx, dy, W - T, HH - 1) || at(dx, dy, W - T, HH))) clr = 1'b1;
                if (se && sf && (at(dx, dy, T - 1, HH - 1) || at(dx, dy, T - 1, HH))) clr = 1'b1;
            end
        end

        if (clr) begin
            hit = HIT_CLEAR;
        end else if (lit) begin
            hit = HIT_LIT;
        end else begin
            hit = HIT_NONE;
        end
    end

endmodule

// ===== rtl/core/ssdps_cfg.sv =====
// APB register file holding style, shadow enable and digit color.
module ssdps_cfg
    import ssdps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output style_t      style,
    output logic        shadow_enable,
    output color_t      digit_red,
    output color_t      digit_green,
    output color_t      digit_blue
);

    style_t   style_reg;
    logic     shadow_reg;
    color_t   red_reg;
    color_t   green_reg;
    color_t   blue_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            style_reg  <= STYLE_DEFAULT;
            shadow_reg <= 1'b0;
            red_reg    <= 8'd0;
            green_reg  <= 8'd255;
            blue_reg   <= 8'd200;
        end else if (wr_en) begin
            unique case (idx)
                REG_STYLE:  style_reg  <= style_t'(pwdata[1:0]);
                REG_SHADOW: shadow_reg <= pwdata[0];
                REG_RED:    red_reg    <= pwdata[7:0];
                REG_GREEN:  green_reg  <= pwdata[7:0];
                REG_BLUE:   blue_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_STYLE:  prdata = {30'd0, style_reg};
            REG_SHADOW: prdata = {31'd0, shadow_reg};
            REG_RED:    prdata = {24'd0, red_reg};
            REG_GREEN:  prdata = {24'd0, green_reg};
            REG_BLUE:   prdata = {24'd0, blue_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign style         = style_reg;
    assign shadow_enable = shadow_reg;
    assign digit_red     = red_reg;
    assign digit_green   = green_reg;
    assign digit_blue    = blue_reg;

endmodule

// ===== rtl/core/seven_segment_digit_pixel_shader_top.sv =====
// Top level: input register, shadow and main pass evaluation, result register.
// Each input transaction passes the input register and then the result register.
// Throughput: one pixel per cycle while m_tready is high; the input register also loads when it is empty.
// Reset (aresetn, synchronous, active low) empties both stages and loads register
// defaults: style 0, shadow off, color (0, 255, 200).
module seven_segment_digit_pixel_shader_top
    import ssdps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // digit_value, origin_x, origin_y, pixel_x, pixel_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_red, out_green, out_blue
    output logic        m_tuser,   // written
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    style_t style;
    logic   shadow_enable;
    color_t digit_red, digit_green, digit_blue;

    ssdps_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .style         (style),
        .shadow_enable (shadow_enable),
        .digit_red     (digit_red),
        .digit_green   (digit_green),
        .digit_blue    (digit_blue)
    );

    logic       in_valid_reg;
    logic [3:0] digit_reg;
    logic [6:0] ox_reg, px_reg;
    logic [4:0] oy_reg, py_reg;

    logic       out_valid_reg;
    logic       written_reg, written_next;
    color_t     red_reg, red_next;
    color_t     green_reg, green_next;
    color_t     blue_reg, blue_next;

    logic out_load;
    logic in_load;

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            digit_reg <= s_tdata[3:0];
            ox_reg    <= s_tdata[10:4];
            oy_reg    <= s_tdata[15:11];
            px_reg    <= s_tdata[22:16];
            py_reg    <= s_tdata[27:23];
        end
    end

    seg_t segs;
    dx_t  dx_main, dx_shadow;
    dy_t  dy_main, dy_shadow;
    hit_t hit_main, hit_shadow;

    assign segs      = digit_segments(digit_reg);
    assign dx_main   = $signed({3'b000, px_reg}) - $signed({3'b000, ox_reg});
    assign dy_main   = $signed({3'b000, py_reg}) - $signed({3'b000, oy_reg});
    assign dx_shadow = dx_main - DX_W'(SHADOW_OFFSET);
    assign dy_shadow = dy_main - DY_W'(SHADOW_OFFSET);

    ssdps_pass u_pass_shadow (
        .segs  (segs),
        .style (style),
        .dx    (dx_shadow),
        .dy    (dy_shadow),
        .hit   (hit_shadow)
    );

    ssdps_pass u_pass_main (
        .segs  (segs),
        .style (style),
        .dx    (dx_main),
        .dy    (dy_main),
        .hit   (hit_main)
    );

    always_comb begin
        written_next = 1'b0;
        red_next     = 8'd0;
        green_next   = 8'd0;
        blue_next    = 8'd0;
        if (digit_reg <= DIGIT_MAX) begin
            if (shadow_enable) begin
                unique case (hit_shadow)
                    HIT_LIT: begin
                        written_next = 1'b1;
                        red_next     = dim_color(digit_red);
                        green_next   = dim_color(digit_green);
                        blue_next    = dim_color(digit_blue);
                    end
                    HIT_CLEAR: begin
                        written_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            unique case (hit_main)
                HIT_LIT: begin
                    written_next = 1'b1;
                    red_next     = digit_red;
                    green_next   = digit_green;
                    blue_next    = digit_blue;
                end
                HIT_CLEAR: begin
                    written_next = 1'b1;
                    red_next     = 8'd0;
                    green_next   = 8'd0;
                    blue_next    = 8'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            written_reg <= written_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {blue_reg, green_reg, red_reg};
    assign m_tuser  = written_reg;

endmodule
